### rtl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed deframer package
// Shared widths and the result item type passed from the parser to the top.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 32;
  localparam int unsigned HdrBytes = 8;
  localparam int unsigned CountW   = 3;
  // Header bytes zero to six are held; the eighth is used as it arrives.
  localparam int unsigned ShiftW   = ByteW * (HdrBytes - 1);

  // One result item as produced by the parser.
  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic [WordW-1:0] message_id;
    logic             first_of_message;
    logic             last_of_message;
    logic             empty_message;
  } result_t;

endpackage

### rtl/length_prefixed_deframer_top.sv
// ----------------------------------------------------------------------------
// Length-prefixed deframer top level
// A result item is registered and appears in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle unless a stalled result holds the input; the output register refills as it drains.
// Header bytes yield no result, but the last one of an empty message yields one; each payload byte yields one.
// Reset clears the parser to header collection and drops any pending result.
// ----------------------------------------------------------------------------
module length_prefixed_deframer_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [lpd_pkg::ByteW-1:0] in_rx_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [lpd_pkg::ByteW-1:0] out_payload_byte,
  output logic [lpd_pkg::WordW-1:0] out_message_id,
  output logic                      out_first_of_message,
  output logic                      out_last_of_message,
  output logic                      out_empty_message
);

  logic             in_accept;
  logic             res_valid;
  lpd_pkg::result_t res;
  logic             out_valid_r, out_valid_nxt;
  lpd_pkg::result_t out_res_r;

  // A new item enters when the output register is empty or being drained.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  lpd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (in_accept),
    .rx_byte     (in_rx_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Output register valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = res_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_payload_byte     = out_res_r.payload_byte;
  assign out_message_id       = out_res_r.message_id;
  assign out_first_of_message = out_res_r.first_of_message;
  assign out_last_of_message  = out_res_r.last_of_message;
  assign out_empty_message    = out_res_r.empty_message;

  // An empty message is a single item, both first and last.
  a_empty_marks : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.empty_message |->
      out_res_r.first_of_message && out_res_r.last_of_message)
    else $error("empty message item lacks first or last mark");

  // An empty message carries a zero byte.
  a_empty_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.empty_message |-> out_res_r.payload_byte == '0)
    else $error("empty message item carries a nonzero byte");

  // A stalled result blocks the input side.
  a_stall_blocks : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted while a result is stalled");

  // A header byte never leaves a new result behind.
  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !res_valid |=> !out_valid_r)
    else $error("result appeared for a byte that yields none");

endmodule

### rtl/lpd_parse.sv
// ----------------------------------------------------------------------------
// Length-prefixed deframer parser
// Collects the eight header bytes, then counts payload bytes down and forms
// the result item for each payload byte or empty message.
// ----------------------------------------------------------------------------
module lpd_parse (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     byte_accept,
  input  logic [lpd_pkg::ByteW-1:0] rx_byte,
  output logic                     res_valid,
  output lpd_pkg::result_t         res
);

  logic [lpd_pkg::ShiftW-1:0] header_shift_r, header_shift_nxt;
  logic [lpd_pkg::CountW-1:0] header_count_r, header_count_nxt;
  logic                       in_payload_r, in_payload_nxt;
  logic [lpd_pkg::WordW-1:0]  bytes_remaining_r, bytes_remaining_nxt;
  logic [lpd_pkg::WordW-1:0]  current_id_r, current_id_nxt;
  logic                       at_first_byte_r, at_first_byte_nxt;

  logic [lpd_pkg::WordW-1:0]  hdr_len;
  logic [lpd_pkg::WordW-1:0]  hdr_id;
  logic                       last_byte;
  logic                       hdr_done;

  // Length is bytes zero to three; the id ends with the byte arriving now.
  assign hdr_len   = header_shift_r[lpd_pkg::WordW-1:0];
  assign hdr_id    = {rx_byte, header_shift_r[lpd_pkg::ShiftW-1:lpd_pkg::WordW]};
  assign last_byte = (bytes_remaining_r <= lpd_pkg::WordW'(1));
  assign hdr_done  = (header_count_r == lpd_pkg::CountW'(lpd_pkg::HdrBytes - 1));

  // Next state and the result item for the byte at the input.
  always_comb begin
    header_shift_nxt    = header_shift_r;
    header_count_nxt    = header_count_r;
    in_payload_nxt      = in_payload_r;
    bytes_remaining_nxt = bytes_remaining_r;
    current_id_nxt      = current_id_r;
    at_first_byte_nxt   = at_first_byte_r;
    res_valid           = 1'b0;
    res.payload_byte     = rx_byte;
    res.message_id       = current_id_r;
    res.first_of_message = at_first_byte_r;
    res.last_of_message  = last_byte;
    res.empty_message    = 1'b0;

    if (in_payload_r) begin
      // Pass a payload byte through and count it off.
      res_valid           = 1'b1;
      at_first_byte_nxt   = 1'b0;
      bytes_remaining_nxt = bytes_remaining_r - lpd_pkg::WordW'(1);
      if (last_byte) begin
        bytes_remaining_nxt = '0;
        in_payload_nxt      = 1'b0;
      end
    end else if (!hdr_done) begin
      // Store one more header byte.
      header_shift_nxt[{header_count_r, 3'b000} +: lpd_pkg::ByteW] = rx_byte;
      header_count_nxt = header_count_r + lpd_pkg::CountW'(1);
    end else begin
      // Last header byte: start the payload or report an empty message.
      header_shift_nxt = '0;
      header_count_nxt = '0;
      current_id_nxt   = hdr_id;
      if (hdr_len == '0) begin
        res_valid            = 1'b1;
        res.payload_byte     = '0;
        res.message_id       = hdr_id;
        res.first_of_message = 1'b1;
        res.last_of_message  = 1'b1;
        res.empty_message    = 1'b1;
        at_first_byte_nxt    = 1'b0;
      end else begin
        bytes_remaining_nxt = hdr_len;
        in_payload_nxt      = 1'b1;
        at_first_byte_nxt   = 1'b1;
      end
    end
  end

  // Parser state advances only on an accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_shift_r    <= '0;
      header_count_r    <= '0;
      in_payload_r      <= 1'b0;
      bytes_remaining_r <= '0;
      current_id_r      <= '0;
      at_first_byte_r   <= 1'b0;
    end else if (byte_accept) begin
      header_shift_r    <= header_shift_nxt;
      header_count_r    <= header_count_nxt;
      in_payload_r      <= in_payload_nxt;
      bytes_remaining_r <= bytes_remaining_nxt;
      current_id_r      <= current_id_nxt;
      at_first_byte_r   <= at_first_byte_nxt;
    end
  end

endmodule
